### rtl/core/tscf_pkg.sv
// Package for the tag sighting confirmation table.
// Holds table sizing, register codes, the entry layout, controller states
// and the command/status structs. Depends on nothing.
package tscf_pkg;

    localparam int TABLE_SLOTS = 24;
    localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    localparam logic [7:0]  COUNT_MAX  = 8'd255;
    localparam logic [31:0] WINDOW_RST = 32'd1000;
    localparam logic [7:0]  REQ_RST    = 8'd2;

    localparam logic REG_WINDOW   = 1'b0;
    localparam logic REG_REQUIRED = 1'b1;

    typedef struct packed {
        logic [31:0] id_high;
        logic [63:0] id_low;
        logic [31:0] first_seen;
        logic [7:0]  count;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS
    } state_t;

    typedef struct packed {
        logic start;
        logic scan;
        logic commit_hit;
        logic commit_miss;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic miss;
        logic out_free;
    } status_t;

endpackage

### rtl/core/tag_sighting_confirmation_table.sv
// Top level of the tag sighting confirmation table.
// Holds the configuration registers; instantiates tscf_ctrl and tscf_dpath.
//
//  channel  | direction | handshake          | payload
//  s_       | in        | s_tvalid/s_tready  | tag_id_high, tag_id_low, now_ms
//  m_       | out       | m_tvalid/m_tready  | confirmed
//  apb      | in        | psel/penable       | window_ms, required_sightings
//
// Each item passes through the accept cycle, a walk that reads one slot per
// cycle from the slot memory with a compare stage behind it, and a commit
// cycle. A hit ends the walk early.
// aresetn is synchronous: it clears valid bits, state and the result valid flag.
// The commit waits while an earlier result is still held on m_.
module tag_sighting_confirmation_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // tag_id_high[31:0], tag_id_low[95:32], now_ms[127:96]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // confirmed[0], zero[7:1]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tscf_pkg::*;

    logic [31:0] window_reg;
    logic [7:0]  required_reg;
    logic        cfg_wr;
    cmd_t        cmd;
    status_t     status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg   <= WINDOW_RST;
            required_reg <= REQ_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_WINDOW:   window_reg   <= pwdata;
                REG_REQUIRED: required_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    assign prdata = (paddr[2] == REG_REQUIRED) ? {24'd0, required_reg} : window_reg;

    tscf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tscf_dpath u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_tdata            (s_tdata),
        .window_ms          (window_reg),
        .required_sightings (required_reg),
        .cmd                (cmd),
        .status             (status),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata)
    );

endmodule

### rtl/core/tscf_ctrl.sv
// Controller of the tag sighting confirmation table.
// Sequences accept, slot walk and commit; depends on tscf_pkg.
module tscf_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  tscf_pkg::status_t status,
    output tscf_pkg::cmd_t    cmd
);
    import tscf_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = !status.hit;
                if (status.hit) begin
                    state_next = ST_HIT;
                end else if (status.miss) begin
                    state_next = ST_MISS;
                end
            end
            ST_HIT: begin
                if (status.out_free) begin
                    cmd.commit_hit = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_MISS: begin
                if (status.out_free) begin
                    cmd.commit_miss = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/tscf_dpath.sv
// Datapath of the tag sighting confirmation table.
// Holds the slot memory, valid bits, compare stage and result register;
// depends on tscf_pkg.
module tscf_dpath (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [127:0]      s_tdata,
    input  logic [31:0]       window_ms,
    input  logic [7:0]        required_sightings,
    input  tscf_pkg::cmd_t    cmd,
    output tscf_pkg::status_t status,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata
);
    import tscf_pkg::*;

    entry_t mem [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [31:0]            id_hi_reg;
    logic [63:0]            id_lo_reg;
    logic [31:0]            now_reg;
    logic [SLOT_W-1:0]      issue_idx_reg;
    logic                   issue_live_reg;
    logic [SLOT_W-1:0]      cmp_idx_reg;
    logic                   cmp_vld_reg;
    entry_t                 rd_entry_reg;
    logic [SLOT_W-1:0]      free_idx_reg;
    logic                   have_free_reg;
    logic                   out_valid_reg;
    logic                   out_conf_reg;

    logic                   cmp_slot_valid;
    logic                   id_match;
    logic [31:0]            age;
    logic                   in_window;
    logic [7:0]             new_count;
    logic [31:0]            new_first;
    logic                   hit_conf;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    entry_t                 wr_entry;

    assign cmp_slot_valid = valid_reg[cmp_idx_reg];
    assign id_match = (rd_entry_reg.id_high == id_hi_reg) && (rd_entry_reg.id_low == id_lo_reg);

    assign status.hit      = cmp_vld_reg && cmp_slot_valid && id_match;
    assign status.miss     = cmp_vld_reg && (cmp_idx_reg == LAST_SLOT) && !status.hit;
    assign status.out_free = !out_valid_reg || m_tready;

    assign age       = now_reg - rd_entry_reg.first_seen;
    assign in_window = age <= window_ms;
    assign new_count = !in_window ? 8'd1 :
                       (rd_entry_reg.count == COUNT_MAX) ? COUNT_MAX :
                       rd_entry_reg.count + 8'd1;
    assign new_first = in_window ? rd_entry_reg.first_seen : now_reg;
    assign hit_conf  = new_count >= required_sightings;

    always_comb begin
        wr_en               = cmd.commit_hit || cmd.commit_miss;
        wr_entry.id_high    = id_hi_reg;
        wr_entry.id_low     = id_lo_reg;
        if (cmd.commit_hit) begin
            wr_addr             = cmp_idx_reg;
            wr_entry.first_seen = new_first;
            wr_entry.count      = new_count;
        end else begin
            wr_addr             = have_free_reg ? free_idx_reg : '0;
            wr_entry.first_seen = now_reg;
            wr_entry.count      = 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_entry;
        end
        if (cmd.scan && issue_live_reg) begin
            rd_entry_reg <= mem[issue_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            id_hi_reg <= s_tdata[31:0];
            id_lo_reg <= s_tdata[95:32];
            now_reg   <= s_tdata[127:96];
        end
        if (cmd.scan && issue_live_reg) begin
            cmp_idx_reg <= issue_idx_reg;
        end
        if (cmd.scan && cmp_vld_reg && !cmp_slot_valid && !have_free_reg) begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (wr_en) begin
            out_conf_reg <= cmd.commit_hit ? hit_conf : (required_sightings <= 8'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            issue_idx_reg  <= '0;
            issue_live_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            have_free_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cmd.start) begin
                issue_idx_reg  <= '0;
                issue_live_reg <= 1'b1;
                cmp_vld_reg    <= 1'b0;
                have_free_reg  <= 1'b0;
            end else if (cmd.scan) begin
                cmp_vld_reg <= issue_live_reg;
                if (issue_live_reg) begin
                    issue_idx_reg  <= issue_idx_reg + SLOT_W'(1);
                    issue_live_reg <= issue_idx_reg != LAST_SLOT;
                end
                if (cmp_vld_reg && !cmp_slot_valid) begin
                    have_free_reg <= 1'b1;
                end
            end
            if (cmd.commit_miss) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (wr_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_conf_reg};

endmodule

### rtl/core/tscf_check.sv
// Port-level checks for the tag sighting confirmation table.
// Bound to tag_sighting_confirmation_table; depends on its ports only.
module tscf_check (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [7:0]   m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while previous item still in the walk");

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_no_result_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result appeared right after accept");

endmodule

bind tag_sighting_confirmation_table tscf_check u_tscf_check (.*);
